// File: design/brl_pkg.sv
// ----------------------------------------------------------------------------
// brl_pkg
// Shared types and constants of the line rasteriser: request and response
// words, command queue entry and the widths derived from the coordinate size.
// ----------------------------------------------------------------------------
`default_nettype none

package brl_pkg;

   // coordinate and field widths
   localparam int CoordBits    = 10;
   localparam int ColourBits   = 8;
   localparam int PixelBits    = 16;
   localparam int StrideBits   = 11;
   localparam int AddrBits     = 20;
   localparam int CountBits    = CoordBits + 1;
   localparam int StraightBits = CoordBits + 2;
   localparam int DecBits      = CoordBits + 3;
   localparam int ProdBits     = StrideBits + CoordBits + 1;
   localparam int WideBits     = (ProdBits > AddrBits) ? ProdBits : AddrBits;

   localparam logic [StrideBits-1:0] StrideReset = StrideBits'(640);

   // command queue depth
   localparam int QueueDepth = 2;
   localparam int QPtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QCntBits   = $clog2(QueueDepth + 1);

   // opcodes
   localparam logic OpLoad = 1'b0;
   localparam logic OpStep = 1'b1;

   typedef struct packed {
      logic                  opcode;
      logic [CoordBits-1:0]  x_start;
      logic [CoordBits-1:0]  y_start;
      logic [CoordBits-1:0]  x_end;
      logic [CoordBits-1:0]  y_end;
      logic [ColourBits-1:0] red;
      logic [ColourBits-1:0] green;
      logic [ColourBits-1:0] blue;
   } req_word_type;

   typedef struct packed {
      logic [CoordBits-1:0] pixel_x;
      logic [CoordBits-1:0] pixel_y;
      logic [AddrBits-1:0]  pixel_address;
      logic [PixelBits-1:0] pixel_colour;
      logic                 last_pixel;
   } rsp_word_type;

   // classified command with line set-up already worked out
   typedef struct packed {
      logic                           opcode;
      logic [CoordBits-1:0]           cur_x;
      logic [CoordBits-1:0]           cur_y;
      logic                           x_down;
      logic                           y_down;
      logic                           x_major;
      logic [StraightBits-1:0]        straight;
      logic signed [DecBits-1:0]      diagonal;
      logic signed [DecBits-1:0]      decision;
      logic [CountBits-1:0]           pixels;
      logic [PixelBits-1:0]           colour;
   } cmd_entry_type;

endpackage

`default_nettype wire

// File: design/brl_queue.sv
// ----------------------------------------------------------------------------
// brl_queue
// Short command queue between front and back; full flag from registered count.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire brl_pkg::cmd_entry_type push_entry,
   output logic                        full,
   input  wire logic                   pop,
   output logic                        head_valid,
   output brl_pkg::cmd_entry_type      head_entry
);

   brl_pkg::cmd_entry_type                 store_ff [brl_pkg::QueueDepth];
   logic [brl_pkg::QPtrBits-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [brl_pkg::QPtrBits-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [brl_pkg::QCntBits-1:0]           count_ff, count_in;
   logic                                   do_push, do_pop;

   assign full       = (count_ff == brl_pkg::QCntBits'(brl_pkg::QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == brl_pkg::QPtrBits'(brl_pkg::QueueDepth - 1)) ?
                     '0 : wr_ptr_ff + brl_pkg::QPtrBits'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == brl_pkg::QPtrBits'(brl_pkg::QueueDepth - 1)) ?
                     '0 : rd_ptr_ff + brl_pkg::QPtrBits'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + brl_pkg::QCntBits'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - brl_pkg::QCntBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: design/brl_front.sv
// ----------------------------------------------------------------------------
// brl_front
// Accepts request words and classifies them; for a load works out the
// Bresenham set-up (deltas, directions, increments, pixel count, RGB565).
// ----------------------------------------------------------------------------
`default_nettype none

module brl_front (
   input  wire logic                   req_valid,
   input  wire brl_pkg::req_word_type  req_word,
   output logic                        req_stall,
   input  wire logic                   queue_full,
   output logic                        push,
   output brl_pkg::cmd_entry_type      push_entry
);

   logic [brl_pkg::CoordBits-1:0] dx, dy, major, minor;
   logic                          x_major;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // take absolute deltas and pick the major axis
   always_comb begin
      dx = (req_word.x_end > req_word.x_start) ? req_word.x_end - req_word.x_start :
                                                 req_word.x_start - req_word.x_end;
      dy = (req_word.y_end > req_word.y_start) ? req_word.y_end - req_word.y_start :
                                                 req_word.y_start - req_word.y_end;
      x_major = (dx >= dy);
      major   = x_major ? dx : dy;
      minor   = x_major ? dy : dx;
   end

   // build the queue word
   always_comb begin
      push_entry.opcode   = req_word.opcode;
      push_entry.cur_x    = req_word.x_start;
      push_entry.cur_y    = req_word.y_start;
      push_entry.x_down   = (req_word.x_start > req_word.x_end);
      push_entry.y_down   = (req_word.y_start > req_word.y_end);
      push_entry.x_major  = x_major;
      push_entry.straight = brl_pkg::StraightBits'({minor, 1'b0});
      push_entry.diagonal = brl_pkg::DecBits'({minor, 1'b0}) -
                            brl_pkg::DecBits'({major, 1'b0});
      push_entry.decision = brl_pkg::DecBits'({minor, 1'b0}) - brl_pkg::DecBits'(major);
      push_entry.pixels   = brl_pkg::CountBits'(major) + brl_pkg::CountBits'(1);
      push_entry.colour   = {req_word.red[7:3], req_word.green[7:2], req_word.blue[7:3]};
   end

endmodule

`default_nettype wire

// File: design/brl_back.sv
// ----------------------------------------------------------------------------
// brl_back
// Holds the active line, walks it one pixel per step command and registers
// each pixel with its frame-buffer address in the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module brl_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [brl_pkg::StrideBits-1:0]      row_stride,
   input  wire logic                                head_valid,
   input  wire brl_pkg::cmd_entry_type              head_entry,
   output logic                                     pop,
   output logic                                     rsp_valid,
   output brl_pkg::rsp_word_type                    rsp_word,
   input  wire logic                                rsp_stall
);

   logic                                active_ff, active_in;
   logic [brl_pkg::CoordBits-1:0]       cur_x_ff, cur_x_in;
   logic [brl_pkg::CoordBits-1:0]       cur_y_ff, cur_y_in;
   logic [brl_pkg::CountBits-1:0]       pixels_ff, pixels_in;
   logic signed [brl_pkg::DecBits-1:0]  decision_ff, decision_in;
   logic [brl_pkg::StraightBits-1:0]    straight_ff, straight_in;
   logic signed [brl_pkg::DecBits-1:0]  diagonal_ff, diagonal_in;
   logic                                x_down_ff, x_down_in;
   logic                                y_down_ff, y_down_in;
   logic                                x_major_ff, x_major_in;
   logic [brl_pkg::PixelBits-1:0]       colour_ff, colour_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   brl_pkg::rsp_word_type               rsp_word_ff, rsp_word_in;

   logic                                out_ready, is_load, emit, last, go_diag;
   logic [brl_pkg::CoordBits-1:0]       next_x, next_y;
   logic [brl_pkg::WideBits-1:0]        addr_wide;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign is_load   = (head_entry.opcode == brl_pkg::OpLoad);
   assign emit      = head_valid && !is_load && active_ff && out_ready;
   assign pop       = head_valid && (is_load || !active_ff || out_ready);
   assign last      = (pixels_ff <= brl_pkg::CountBits'(1));
   assign go_diag   = !decision_ff[brl_pkg::DecBits-1] && (decision_ff != '0);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // step coordinates along the line
   always_comb begin
      next_x = cur_x_ff;
      next_y = cur_y_ff;
      if (go_diag || x_major_ff) begin
         next_x = x_down_ff ? cur_x_ff - brl_pkg::CoordBits'(1) :
                              cur_x_ff + brl_pkg::CoordBits'(1);
      end
      if (go_diag || !x_major_ff) begin
         next_y = y_down_ff ? cur_y_ff - brl_pkg::CoordBits'(1) :
                              cur_y_ff + brl_pkg::CoordBits'(1);
      end
   end

   // load or advance line state
   always_comb begin
      active_in   = active_ff;
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      pixels_in   = pixels_ff;
      decision_in = decision_ff;
      straight_in = straight_ff;
      diagonal_in = diagonal_ff;
      x_down_in   = x_down_ff;
      y_down_in   = y_down_ff;
      x_major_in  = x_major_ff;
      colour_in   = colour_ff;
      if (pop && is_load) begin
         active_in   = 1'b1;
         cur_x_in    = head_entry.cur_x;
         cur_y_in    = head_entry.cur_y;
         pixels_in   = head_entry.pixels;
         decision_in = head_entry.decision;
         straight_in = head_entry.straight;
         diagonal_in = head_entry.diagonal;
         x_down_in   = head_entry.x_down;
         y_down_in   = head_entry.y_down;
         x_major_in  = head_entry.x_major;
         colour_in   = head_entry.colour;
      end else if (emit) begin
         cur_x_in    = next_x;
         cur_y_in    = next_y;
         decision_in = go_diag ? decision_ff + diagonal_ff :
                                 decision_ff + brl_pkg::DecBits'(straight_ff);
         if (last) begin
            pixels_in = '0;
            active_in = 1'b0;
         end else begin
            pixels_in = pixels_ff - brl_pkg::CountBits'(1);
         end
      end
   end

   // form the pixel word and address
   always_comb begin
      addr_wide = brl_pkg::WideBits'(row_stride) * brl_pkg::WideBits'(cur_y_ff) +
                  brl_pkg::WideBits'(cur_x_ff);
      rsp_word_in.pixel_x       = cur_x_ff;
      rsp_word_in.pixel_y       = cur_y_ff;
      rsp_word_in.pixel_address = addr_wide[brl_pkg::AddrBits-1:0];
      rsp_word_in.pixel_colour  = colour_ff;
      rsp_word_in.last_pixel    = last;
      rsp_valid_in              = out_ready ? emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         pixels_ff    <= '0;
         decision_ff  <= '0;
         straight_ff  <= '0;
         diagonal_ff  <= '0;
         x_down_ff    <= 1'b0;
         y_down_ff    <= 1'b0;
         x_major_ff   <= 1'b0;
         colour_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         pixels_ff    <= pixels_in;
         decision_ff  <= decision_in;
         straight_ff  <= straight_in;
         diagonal_ff  <= diagonal_in;
         x_down_ff    <= x_down_in;
         y_down_ff    <= y_down_in;
         x_major_ff   <= x_major_in;
         colour_ff    <= colour_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the output word until taken
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

endmodule

`default_nettype wire

// File: design/bresenham_line_rasterizer_core.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_core
// Line rasteriser: a load word sets up a Bresenham walk, each step word on an
// active line returns one pixel with its frame-buffer address and RGB565 colour.
// ----------------------------------------------------------------------------
// A step word is queued when it is accepted; the back end then walks it and
// registers its pixel in the output register; an output stall can hold it back.
// Throughput: one word per cycle, loads and steps alike, set by the back
// end taking one queue entry per cycle while the output register drains.
// Reset (synchronous): no active line, queue empty, row stride 640.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_rasterizer_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire brl_pkg::req_word_type          req_word,
   output logic                                req_stall,
   output logic                                rsp_valid,
   output brl_pkg::rsp_word_type               rsp_word,
   input  wire logic                           rsp_stall,
   input  wire logic                           csr_wr_en,
   input  wire logic [brl_pkg::StrideBits-1:0] csr_wr_data
);

   logic [brl_pkg::StrideBits-1:0] row_stride_ff, row_stride_in;
   logic                           queue_full, push, pop, head_valid;
   brl_pkg::cmd_entry_type         push_entry, head_entry;

   // write the row stride register
   assign row_stride_in = csr_wr_en ? csr_wr_data : row_stride_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_stride_ff <= brl_pkg::StrideReset;
      end else begin
         row_stride_ff <= row_stride_in;
      end
   end

   brl_front u_front (
      .req_valid  (req_valid),
      .req_word   (req_word),
      .req_stall  (req_stall),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   brl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   brl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .row_stride (row_stride_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word),
      .rsp_stall  (rsp_stall)
   );

endmodule

`default_nettype wire
